>>> src/sfcd_pkg.sv
`timescale 1ns / 1ps

package sfcd_pkg;

   localparam int HEADER_BYTES_DEF  = 12;
   localparam int LENGTH_OFFSET_DEF = 10;
   localparam int FIFO_DEPTH_DEF    = 4;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD = 2'd2;

   localparam logic [7:0]  SYNC_FIRST_RESET  = 8'd69;
   localparam logic [7:0]  SYNC_SECOND_RESET = 8'd88;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_MAPPED = 16'hAAAA;

   localparam logic [2:0] ROLE_DISCARD = 3'd0;
   localparam logic [2:0] ROLE_SYNC    = 3'd1;
   localparam logic [2:0] ROLE_HEADER  = 3'd2;
   localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
   localparam logic [2:0] ROLE_CRC     = 3'd4;

   localparam logic [1:0] VERDICT_NONE      = 2'd0;
   localparam logic [1:0] VERDICT_GOOD      = 2'd1;
   localparam logic [1:0] VERDICT_CRC_BAD   = 2'd2;
   localparam logic [1:0] VERDICT_TOO_LARGE = 2'd3;

   typedef enum logic [2:0] {
      KIND_DISCARD,
      KIND_SYNC,
      KIND_SYNC_LAST,
      KIND_HEADER,
      KIND_PAYLOAD,
      KIND_CRC_HIGH,
      KIND_CRC_LAST,
      KIND_REJECT
   } kind_type;

   typedef enum logic [2:0] {
      ST_HUNT_FIRST,
      ST_HUNT_SECOND,
      ST_HEADER,
      ST_CHECK,
      ST_BODY
   } front_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      kind_type   kind;
   } item_type;

   // ccitt poly 0x1021, one byte, msb first
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = {crc[7:0], crc[15:8]};
      c[7:0] = c[7:0] ^ b;
      c = c ^ {12'b0, c[7:4]};
      c = c ^ {c[3:0], 12'b0};
      c = c ^ {3'b0, c[7:0], 5'b0};
      return c;
   endfunction

endpackage

>>> src/sfcd_front.sv
`timescale 1ns / 1ps

module sfcd_front #(
   parameter int HEADER_BYTES  = sfcd_pkg::HEADER_BYTES_DEF,
   parameter int LENGTH_OFFSET = sfcd_pkg::LENGTH_OFFSET_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [sfcd_pkg::CSR_INDEX_W-1:0]   csr_addr,
   input  logic [sfcd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,
   input  logic                               queue_full,
   output logic                               push,
   output sfcd_pkg::item_type                 push_item
);

   localparam int PosW = $clog2(HEADER_BYTES);

   sfcd_pkg::front_state_type state_ff, state_in;
   logic [PosW-1:0]  pos_ff, pos_in;
   logic [15:0]      length_ff, length_in;
   logic [16:0]      remain_ff, remain_in;
   logic [7:0]       sync_first_ff;
   logic [7:0]       sync_second_ff;
   logic [15:0]      max_payload_ff;
   sfcd_pkg::kind_type kind;
   logic             accept;
   logic [7:0]       b;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign push       = accept;
   assign push_item  = '{data_byte: b, kind: kind};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sfcd_pkg::ST_HUNT_FIRST: begin
            if (accept && b == sync_first_ff) state_in = sfcd_pkg::ST_HUNT_SECOND;
         end
         sfcd_pkg::ST_HUNT_SECOND: begin
            if (accept) begin
               state_in = (b == sync_second_ff) ? sfcd_pkg::ST_HEADER
                                                : sfcd_pkg::ST_HUNT_FIRST;
            end
         end
         sfcd_pkg::ST_HEADER: begin
            if (accept && pos_ff == PosW'(HEADER_BYTES - 1)) state_in = sfcd_pkg::ST_CHECK;
         end
         sfcd_pkg::ST_CHECK: begin
            if (accept) begin
               state_in = (length_ff > max_payload_ff) ? sfcd_pkg::ST_HUNT_FIRST
                                                       : sfcd_pkg::ST_BODY;
            end
         end
         sfcd_pkg::ST_BODY: begin
            if (accept && remain_ff == 17'd1) state_in = sfcd_pkg::ST_HUNT_FIRST;
         end
         default: state_in = sfcd_pkg::ST_HUNT_FIRST;
      endcase
   end

   always_comb begin
      kind      = sfcd_pkg::KIND_DISCARD;
      pos_in    = pos_ff;
      length_in = length_ff;
      remain_in = remain_ff;
      case (state_ff)
         sfcd_pkg::ST_HUNT_FIRST: begin
            if (b == sync_first_ff) kind = sfcd_pkg::KIND_SYNC;
         end
         sfcd_pkg::ST_HUNT_SECOND: begin
            // a repeated first sync byte here is dropped, not taken as a new start
            if (b == sync_second_ff) begin
               kind      = sfcd_pkg::KIND_SYNC_LAST;
               length_in = 16'd0;
               pos_in    = PosW'(2);
            end
         end
         sfcd_pkg::ST_HEADER: begin
            kind   = sfcd_pkg::KIND_HEADER;
            pos_in = pos_ff + PosW'(1);
            if (32'(pos_ff) == 32'(LENGTH_OFFSET)) length_in = {length_ff[15:8], b};
            else if (32'(pos_ff) == 32'(LENGTH_OFFSET + 1)) length_in = {b, length_ff[7:0]};
         end
         sfcd_pkg::ST_CHECK: begin
            if (length_ff > max_payload_ff) begin
               kind = sfcd_pkg::KIND_REJECT;
            end else begin
               // length plus two crc bytes, minus this one
               remain_in = {1'b0, length_ff} + 17'd1;
               kind = (remain_in >= 17'd2) ? sfcd_pkg::KIND_PAYLOAD : sfcd_pkg::KIND_CRC_HIGH;
            end
         end
         sfcd_pkg::ST_BODY: begin
            remain_in = remain_ff - 17'd1;
            if (remain_in >= 17'd2) kind = sfcd_pkg::KIND_PAYLOAD;
            else if (remain_in == 17'd1) kind = sfcd_pkg::KIND_CRC_HIGH;
            else kind = sfcd_pkg::KIND_CRC_LAST;
         end
         default: kind = sfcd_pkg::KIND_DISCARD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sfcd_pkg::ST_HUNT_FIRST;
         pos_ff    <= '0;
         length_ff <= '0;
         remain_ff <= '0;
      end else if (accept) begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         length_ff <= length_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= sfcd_pkg::SYNC_FIRST_RESET;
         sync_second_ff <= sfcd_pkg::SYNC_SECOND_RESET;
         max_payload_ff <= sfcd_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            sfcd_pkg::CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata[7:0];
            sfcd_pkg::CSR_SYNC_SECOND: sync_second_ff <= csr_wdata[7:0];
            sfcd_pkg::CSR_MAX_PAYLOAD: max_payload_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

>>> src/sfcd_fifo.sv
`timescale 1ns / 1ps

module sfcd_fifo #(
   parameter int DEPTH = sfcd_pkg::FIFO_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sfcd_pkg::item_type push_item,
   input  logic               pop,
   output sfcd_pkg::item_type pop_item,
   output logic               full,
   output logic               empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   sfcd_pkg::item_type entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full     = count_ff == CntW'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      if (push && !pop) count_in = count_ff + CntW'(1);
      else if (pop && !push) count_in = count_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

>>> src/sfcd_back.sv
`timescale 1ns / 1ps

module sfcd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  sfcd_pkg::item_type pop_item,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic [4:0]         rsp_tuser,
   output logic               rsp_tlast
);

   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff;
   logic [2:0]  role_ff, role_in;
   logic        last_ff, last_in;
   logic [1:0]  verdict_ff, verdict_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_high_ff, crc_high_in;
   logic [15:0] crc_calc;

   assign pop = !empty && (!valid_ff || rsp_tready);

   assign crc_calc = (crc_ff == sfcd_pkg::CRC_INIT) ? sfcd_pkg::CRC_MAPPED : crc_ff;

   always_comb begin
      valid_in    = valid_ff && !rsp_tready;
      role_in     = sfcd_pkg::ROLE_DISCARD;
      last_in     = 1'b0;
      verdict_in  = sfcd_pkg::VERDICT_NONE;
      crc_in      = crc_ff;
      crc_high_in = crc_high_ff;
      if (pop) begin
         valid_in = 1'b1;
         case (pop_item.kind)
            sfcd_pkg::KIND_DISCARD: role_in = sfcd_pkg::ROLE_DISCARD;
            sfcd_pkg::KIND_SYNC:    role_in = sfcd_pkg::ROLE_SYNC;
            sfcd_pkg::KIND_SYNC_LAST: begin
               role_in = sfcd_pkg::ROLE_SYNC;
               crc_in  = sfcd_pkg::CRC_INIT;
            end
            sfcd_pkg::KIND_HEADER: begin
               role_in = sfcd_pkg::ROLE_HEADER;
               crc_in  = sfcd_pkg::crc_update(crc_ff, pop_item.data_byte);
            end
            sfcd_pkg::KIND_PAYLOAD: begin
               role_in = sfcd_pkg::ROLE_PAYLOAD;
               crc_in  = sfcd_pkg::crc_update(crc_ff, pop_item.data_byte);
            end
            sfcd_pkg::KIND_CRC_HIGH: begin
               role_in     = sfcd_pkg::ROLE_CRC;
               crc_high_in = pop_item.data_byte;
            end
            sfcd_pkg::KIND_CRC_LAST: begin
               role_in    = sfcd_pkg::ROLE_CRC;
               last_in    = 1'b1;
               verdict_in = (crc_calc == {crc_high_ff, pop_item.data_byte})
                            ? sfcd_pkg::VERDICT_GOOD : sfcd_pkg::VERDICT_CRC_BAD;
               crc_in     = sfcd_pkg::CRC_INIT;
            end
            sfcd_pkg::KIND_REJECT: begin
               role_in    = sfcd_pkg::ROLE_DISCARD;
               last_in    = 1'b1;
               verdict_in = sfcd_pkg::VERDICT_TOO_LARGE;
               crc_in     = sfcd_pkg::CRC_INIT;
            end
            default: role_in = sfcd_pkg::ROLE_DISCARD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         crc_ff      <= sfcd_pkg::CRC_INIT;
         crc_high_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         crc_ff      <= crc_in;
         crc_high_ff <= crc_high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         byte_ff    <= pop_item.data_byte;
         role_ff    <= role_in;
         last_ff    <= last_in;
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = {verdict_ff, role_ff};
   assign rsp_tlast  = last_ff;

endmodule

>>> src/sync_frame_crc_deframer_top.sv
`timescale 1ns / 1ps

// channel | dir | ports                          | contents
// req     | in  | req_tvalid/tready/tdata        | tdata[7:0] data_byte
// rsp     | out | rsp_tvalid/tready/tdata/tuser/ | tdata[7:0] byte_out, tuser byte_role,
//         |     | tlast                          | verdict; tlast frame_end
// csr     | in  | csr_we/addr/wdata              | sync_first, sync_second, max_payload
//
// one byte per cycle sustained unless rsp stalls; a byte reaches rsp after its req
// transfer through a queue entry, then the crc/verdict output register
// crc unit: one byte per cycle unless stalled, fed by a small queue from the classifier
// reset is synchronous; no clearing pass, the block takes bytes once reset is released
// req_tready drops only when the queue fills while rsp is stalled

module sync_frame_crc_deframer_top #(
   parameter int HEADER_BYTES  = sfcd_pkg::HEADER_BYTES_DEF,
   parameter int LENGTH_OFFSET = sfcd_pkg::LENGTH_OFFSET_DEF,
   parameter int FIFO_DEPTH    = sfcd_pkg::FIFO_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [sfcd_pkg::CSR_INDEX_W-1:0] csr_addr,
   input  logic [sfcd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] data_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,   // [7:0] byte_out
   output logic [4:0]                       rsp_tuser,   // [2:0] byte_role, [4:3] verdict
   output logic                             rsp_tlast
);

   logic               push;
   logic               pop;
   logic               full;
   logic               empty;
   sfcd_pkg::item_type push_item;
   sfcd_pkg::item_type pop_item;

   sfcd_front #(
      .HEADER_BYTES  (HEADER_BYTES),
      .LENGTH_OFFSET (LENGTH_OFFSET)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (full),
      .push       (push),
      .push_item  (push_item)
   );

   sfcd_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .full      (full),
      .empty     (empty)
   );

   sfcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> src/sfcd_checker.sv
`timescale 1ns / 1ps

module sfcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [4:0] rsp_tuser,
   input logic       rsp_tlast
);

   logic [2:0] role;
   logic [1:0] verdict;

   assign role    = rsp_tuser[2:0];
   assign verdict = rsp_tuser[4:3];

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_stall_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp valid dropped while stalled");

   a_stall_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("rsp transfer changed while stalled");

   a_no_verdict_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> verdict == sfcd_pkg::VERDICT_NONE)
      else $error("verdict outside frame end");

   a_end_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         (role == sfcd_pkg::ROLE_CRC && (verdict == sfcd_pkg::VERDICT_GOOD
                                        || verdict == sfcd_pkg::VERDICT_CRC_BAD))
         || (role == sfcd_pkg::ROLE_DISCARD && verdict == sfcd_pkg::VERDICT_TOO_LARGE))
      else $error("frame end with inconsistent role and verdict");

endmodule

bind sync_frame_crc_deframer_top sfcd_checker u_checker (.*);
